// File: hw/rtl/cleb_pkg.sv
// Shared constants, codes and types of the cursor line-edit buffer.
package cleb_pkg;

    localparam int CAPACITY = 4096;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY) + 1;
    localparam int CHAR_W   = 8;
    localparam int POS_W    = 12;

    typedef enum logic [2:0] {
        ACT_LEFT   = 3'd0,
        ACT_RIGHT  = 3'd1,
        ACT_BACK   = 3'd2,
        ACT_INSERT = 3'd3,
        ACT_READ   = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EDGE  = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // One write of a stack memory.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CHAR_W-1:0] data;
    } t_mem_wr;

endpackage

// File: hw/rtl/cleb_stack_ram.sv
// Stack memory of the edit buffer: one write port, one read port with registered data.
module cleb_stack_ram (
    input  logic                      i_clk,
    input  cleb_pkg::t_mem_wr         i_wr,
    input  logic                      i_rd_en,
    input  logic [cleb_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [cleb_pkg::CHAR_W-1:0] o_rd_data
);
    import cleb_pkg::*;

    logic [CHAR_W-1:0] r_mem [CAPACITY];
    logic [CHAR_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/cursor_line_edit_buffer.sv
// Top level of the cursor line-edit buffer: decode, stack memories and result register.
// A result is loaded into the result register from the execute state entered at acceptance.
// A new request is taken only after the last one is written back; the registered read of the
// stack memories lies ahead of the write-back of the moved or inserted byte.
// Reset (synchronous, active low) clears the state, both stack counts and the valid flag;
// memory contents are left as they are and need no clearing pass.
module cursor_line_edit_buffer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [2:0]                  i_action,
    input  logic [cleb_pkg::CHAR_W-1:0] i_character,
    input  logic [cleb_pkg::POS_W-1:0]  i_position,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_status,
    output logic [cleb_pkg::CHAR_W-1:0] o_read_char,
    output logic [cleb_pkg::CNT_W-1:0]  o_text_length,
    output logic [cleb_pkg::CNT_W-1:0]  o_cursor_pos
);
    import cleb_pkg::*;

    // Stack counts: the left stack holds the text before the cursor in order,
    // the right stack holds the text after it with the nearest byte on top.
    logic [CNT_W-1:0]  r_left_count, n_left_count;
    logic [CNT_W-1:0]  r_right_count, n_right_count;

    t_state            r_state, n_state;

    // Request captured at acceptance, with its outcome already decided.
    t_action           r_op;
    t_status           r_req_status;
    logic [CHAR_W-1:0] r_char;
    logic              r_rd_left;

    // Result register.
    logic              r_out_valid;
    logic [1:0]        r_out_status;
    logic [CHAR_W-1:0] r_out_char;
    logic [CNT_W-1:0]  r_out_len;
    logic [CNT_W-1:0]  r_out_cursor;

    logic              accept;
    logic              exec_go;

    logic [CNT_W-1:0]  len;
    logic [CNT_W-1:0]  pos_ext;
    logic [CNT_W-1:0]  right_idx;
    t_status           dec_status;
    logic              dec_rd_left;

    logic              left_rd_en, right_rd_en;
    logic [ADDR_W-1:0] left_rd_addr, right_rd_addr;
    logic [CHAR_W-1:0] left_rd_data, right_rd_data;
    t_mem_wr           left_wr, right_wr;
    logic [CHAR_W-1:0] exec_char;

    assign len       = r_left_count + r_right_count;
    assign pos_ext   = {{(CNT_W - POS_W){1'b0}}, i_position};
    // Position from the end of the text maps straight onto the right stack.
    assign right_idx = len - pos_ext - CNT_W'(1);

    // ---------------------------------------------------------------------
    // State machine: next state.
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State machine: outputs. A request is taken only in idle; the write-back
    // waits while the result register still holds an untaken result.
    always_comb begin
        o_stall = 1'b1;
        exec_go = 1'b0;
        unique case (r_state)
            S_IDLE: o_stall = 1'b0;
            S_EXEC: exec_go = !r_out_valid || !i_stall;
            default: o_stall = 1'b1;
        endcase
    end

    assign accept = i_valid && !o_stall;

    // ---------------------------------------------------------------------
    // Decode at acceptance: decide the status and issue the memory read.
    // ---------------------------------------------------------------------
    always_comb begin
        dec_status    = ST_EDGE;
        dec_rd_left   = 1'b1;
        left_rd_en    = 1'b0;
        right_rd_en   = 1'b0;
        left_rd_addr  = r_left_count[ADDR_W-1:0] - ADDR_W'(1);
        right_rd_addr = r_right_count[ADDR_W-1:0] - ADDR_W'(1);
        unique case (t_action'(i_action))
            ACT_LEFT: begin
                if (r_left_count != '0 && r_right_count < CNT_W'(CAPACITY)) begin
                    dec_status = ST_DONE;
                    left_rd_en = accept;
                end
            end
            ACT_RIGHT: begin
                if (r_right_count != '0 && r_left_count < CNT_W'(CAPACITY)) begin
                    dec_status  = ST_DONE;
                    right_rd_en = accept;
                end
            end
            ACT_BACK: begin
                if (r_left_count != '0) begin
                    dec_status = ST_DONE;
                end
            end
            ACT_INSERT: begin
                if (len >= CNT_W'(CAPACITY)) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_status = ST_DONE;
                end
            end
            ACT_READ: begin
                if (pos_ext >= len) begin
                    dec_status = ST_RANGE;
                end else if (pos_ext < r_left_count) begin
                    dec_status   = ST_DONE;
                    left_rd_en   = accept;
                    left_rd_addr = i_position[ADDR_W-1:0];
                end else begin
                    dec_status    = ST_DONE;
                    dec_rd_left   = 1'b0;
                    right_rd_en   = accept;
                    right_rd_addr = right_idx[ADDR_W-1:0];
                end
            end
            default: dec_status = ST_EDGE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op         <= t_action'(i_action);
            r_req_status <= dec_status;
            r_char       <= i_character;
            r_rd_left    <= dec_rd_left;
        end
    end

    // ---------------------------------------------------------------------
    // Write-back: move, insert or delete one byte, or pick the read byte, and update the counts.
    // ---------------------------------------------------------------------
    always_comb begin
        n_left_count  = r_left_count;
        n_right_count = r_right_count;
        left_wr       = '0;
        right_wr      = '0;
        exec_char     = '0;
        left_wr.addr  = r_left_count[ADDR_W-1:0];
        right_wr.addr = r_right_count[ADDR_W-1:0];
        if (exec_go && r_req_status == ST_DONE) begin
            unique case (r_op)
                ACT_LEFT: begin
                    right_wr.en   = 1'b1;
                    right_wr.data = left_rd_data;
                    n_left_count  = r_left_count - CNT_W'(1);
                    n_right_count = r_right_count + CNT_W'(1);
                end
                ACT_RIGHT: begin
                    // The byte lands where the cursor was, at the old left count.
                    left_wr.en    = 1'b1;
                    left_wr.data  = right_rd_data;
                    n_left_count  = r_left_count + CNT_W'(1);
                    n_right_count = r_right_count - CNT_W'(1);
                end
                ACT_BACK: begin
                    n_left_count = r_left_count - CNT_W'(1);
                end
                ACT_INSERT: begin
                    left_wr.en   = 1'b1;
                    left_wr.data = r_char;
                    n_left_count = r_left_count + CNT_W'(1);
                end
                ACT_READ: begin
                    exec_char = r_rd_left ? left_rd_data : right_rd_data;
                end
                default: exec_char = '0;
            endcase
        end
    end

    cleb_stack_ram u_left_ram (
        .i_clk     (i_clk),
        .i_wr      (left_wr),
        .i_rd_en   (left_rd_en),
        .i_rd_addr (left_rd_addr),
        .o_rd_data (left_rd_data)
    );

    cleb_stack_ram u_right_ram (
        .i_clk     (i_clk),
        .i_wr      (right_wr),
        .i_rd_en   (right_rd_en),
        .i_rd_addr (right_rd_addr),
        .o_rd_data (right_rd_data)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_left_count  <= '0;
            r_right_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_left_count  <= n_left_count;
            r_right_count <= n_right_count;
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: loaded once per request, held while stalled.
    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_out_status <= r_req_status;
            r_out_char   <= exec_char;
            r_out_len    <= n_left_count + n_right_count;
            r_out_cursor <= n_left_count;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_read_char   = r_out_char;
    assign o_text_length = r_out_len;
    assign o_cursor_pos  = r_out_cursor;

endmodule
